// ===== sv/mm_pkg.sv =====
`timescale 1ns / 1ps
// Package for the matrix multiply block: field widths, opcodes, register
// indexes and the command and status structs between controller and datapath.
// No dependencies.
package mm_pkg;

	// Field widths, fixed by the item formats
	localparam int OPC_W     = 2;
	localparam int IDX_W     = 3;
	localparam int VAL_W     = 16;
	localparam int PROD_W    = 2 * VAL_W;
	localparam int SUM_W     = 36;
	localparam int CFG_W     = 4;
	localparam int CFG_IDX_W = 2;

	// Reach of the 3-bit row and column fields
	localparam int INDEX_REACH = 8;

	// Default store side length
	localparam int MAX_DIM_DEF = 8;

	// Size register reset value
	localparam logic [CFG_W-1:0] DIM_RESET = 4'd8;

	// Opcodes
	localparam logic [OPC_W-1:0] OP_LOAD_A  = 2'd0;
	localparam logic [OPC_W-1:0] OP_LOAD_B  = 2'd1;
	localparam logic [OPC_W-1:0] OP_COMPUTE = 2'd2;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_ROWS_A    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_INNER_DIM = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_COLS_B    = 2'd2;

	// Controller to datapath
	typedef struct packed {
		logic             load_a;
		logic             load_b;
		logic [IDX_W-1:0] ld_row;
		logic [IDX_W-1:0] ld_col;
		logic [VAL_W-1:0] ld_value;
		logic             issue;
		logic             k_first;
		logic             k_last;
		logic             last_elem;
		logic [IDX_W-1:0] i;
		logic [IDX_W-1:0] j;
		logic [IDX_W-1:0] k;
	} mm_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic adv;
	} mm_sts_t;

	// Tag that travels with each product through the pipeline
	typedef struct packed {
		logic             valid;
		logic             k_first;
		logic             k_last;
		logic             last_elem;
		logic [IDX_W-1:0] row;
		logic [IDX_W-1:0] col;
	} mm_tag_t;

endpackage

// ===== sv/mm_ifs.sv =====
`timescale 1ns / 1ps
// Channel interfaces of the matrix multiply block: input items, result items
// and configuration writes. Depends on mm_pkg.

interface mm_item_if;
	import mm_pkg::*;
	logic                    valid;
	logic                    ready;
	logic [OPC_W-1:0]        opcode;
	logic [IDX_W-1:0]        row;
	logic [IDX_W-1:0]        col;
	logic signed [VAL_W-1:0] value;

	modport source (output valid, opcode, row, col, value, input ready);
	modport sink   (input valid, opcode, row, col, value, output ready);
endinterface

interface mm_result_if;
	import mm_pkg::*;
	logic                    valid;
	logic                    ready;
	logic [IDX_W-1:0]        out_row;
	logic [IDX_W-1:0]        out_col;
	logic signed [SUM_W-1:0] out_value;
	logic                    last;

	modport source (output valid, out_row, out_col, out_value, last, input ready);
	modport sink   (input valid, out_row, out_col, out_value, last, output ready);
endinterface

interface mm_cfg_if;
	import mm_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [CFG_W-1:0]     data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

// ===== sv/mm_ram.sv =====
`timescale 1ns / 1ps
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module mm_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read, held while re is low
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== sv/mm_ctrl.sv =====
`timescale 1ns / 1ps
// Controller of the matrix multiply block: size registers, input handshake
// and the row/column/inner loop counters. Depends on mm_pkg and mm_ifs.
module mm_ctrl #(
	parameter int MAX_DIM = mm_pkg::MAX_DIM_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	mm_item_if.sink         item,
	mm_cfg_if.sink          cfg,
	input  mm_pkg::mm_sts_t sts,
	output mm_pkg::mm_cmd_t cmd
);
	import mm_pkg::*;

	// Largest usable size: store side or index reach, whichever is smaller
	localparam int DIM_LIM = (MAX_DIM < INDEX_REACH) ? MAX_DIM : INDEX_REACH;

	localparam logic S_IDLE = 1'b0;
	localparam logic S_RUN  = 1'b1;

	logic             state_q;
	logic [CFG_W-1:0] rows_a_q;
	logic [CFG_W-1:0] inner_dim_q;
	logic [CFG_W-1:0] cols_b_q;
	logic [IDX_W-1:0] i_q;
	logic [IDX_W-1:0] j_q;
	logic [IDX_W-1:0] k_q;
	logic [IDX_W-1:0] nr_m1;
	logic [IDX_W-1:0] nk_m1;
	logic [IDX_W-1:0] nc_m1;
	logic             accept;
	logic             step;
	logic             k_end;
	logic             j_end;
	logic             i_end;

	// Size register clamped to 1..DIM_LIM, minus one
	function automatic logic [IDX_W-1:0] dim_m1(input logic [CFG_W-1:0] d);
		logic [CFG_W-1:0] c;
		c = d;
		if (d == '0) begin
			c = CFG_W'(1);
		end else if (d > CFG_W'(DIM_LIM)) begin
			c = CFG_W'(DIM_LIM);
		end
		dim_m1 = IDX_W'(c - CFG_W'(1));
	endfunction

	assign nr_m1 = dim_m1(rows_a_q);
	assign nk_m1 = dim_m1(inner_dim_q);
	assign nc_m1 = dim_m1(cols_b_q);

	// Configuration writes, always taken
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_a_q    <= DIM_RESET;
			inner_dim_q <= DIM_RESET;
			cols_b_q    <= DIM_RESET;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_ROWS_A:    rows_a_q    <= cfg.data;
				REG_INNER_DIM: inner_dim_q <= cfg.data;
				REG_COLS_B:    cols_b_q    <= cfg.data;
				default: ;
			endcase
		end
	end

	// Items are taken only while no product sweep is being issued
	assign item.ready = (state_q == S_IDLE);
	assign accept     = item.valid && item.ready;

	assign step  = (state_q == S_RUN) && sts.adv;
	assign k_end = (k_q == nk_m1);
	assign j_end = (j_q == nc_m1);
	assign i_end = (i_q == nr_m1);

	// State and loop counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			i_q     <= '0;
			j_q     <= '0;
			k_q     <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept && item.opcode == OP_COMPUTE) begin
						state_q <= S_RUN;
						i_q     <= '0;
						j_q     <= '0;
						k_q     <= '0;
					end
				end
				S_RUN: begin
					if (step) begin
						if (k_end) begin
							k_q <= '0;
							if (j_end) begin
								j_q <= '0;
								if (i_end) begin
									state_q <= S_IDLE;
								end else begin
									i_q <= i_q + 1'b1;
								end
							end else begin
								j_q <= j_q + 1'b1;
							end
						end else begin
							k_q <= k_q + 1'b1;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Commands to the datapath
	always_comb begin
		cmd           = '0;
		cmd.load_a    = accept && (item.opcode == OP_LOAD_A);
		cmd.load_b    = accept && (item.opcode == OP_LOAD_B);
		cmd.ld_row    = item.row;
		cmd.ld_col    = item.col;
		cmd.ld_value  = item.value;
		cmd.issue     = (state_q == S_RUN);
		cmd.k_first   = (k_q == '0);
		cmd.k_last    = k_end;
		cmd.last_elem = i_end && j_end;
		cmd.i         = i_q;
		cmd.j         = j_q;
		cmd.k         = k_q;
	end

endmodule

// ===== sv/mm_dp.sv =====
`timescale 1ns / 1ps
// Datapath of the matrix multiply block: A and B stores, multiplier,
// accumulator and result register. Depends on mm_pkg, mm_ifs and mm_ram.
module mm_dp #(
	parameter int MAX_DIM = mm_pkg::MAX_DIM_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  mm_pkg::mm_cmd_t cmd,
	output mm_pkg::mm_sts_t sts,
	mm_result_if.source     result
);
	import mm_pkg::*;

	localparam int DEPTH  = MAX_DIM * MAX_DIM;
	localparam int ADDR_W = $clog2(DEPTH);

	logic                     adv;
	logic                     ld_in_range;
	logic [ADDR_W-1:0]        waddr;
	logic [ADDR_W-1:0]        a_raddr;
	logic [ADDR_W-1:0]        b_raddr;
	logic [VAL_W-1:0]         a_rdata;
	logic [VAL_W-1:0]         b_rdata;
	mm_tag_t                  tag_s1;
	mm_tag_t                  tag_s2;
	logic signed [PROD_W-1:0] prod_s2;
	logic signed [SUM_W-1:0]  acc_q;
	logic signed [SUM_W-1:0]  sum;
	logic                     out_valid_q;
	logic [IDX_W-1:0]         out_row_q;
	logic [IDX_W-1:0]         out_col_q;
	logic signed [SUM_W-1:0]  out_value_q;
	logic                     out_last_q;

	// Whole pipeline moves unless a finished result is still waiting
	assign adv     = !out_valid_q || result.ready;
	assign sts.adv = adv;

	// Load address, out-of-range loads dropped
	assign ld_in_range = (32'(cmd.ld_row) < 32'(MAX_DIM)) && (32'(cmd.ld_col) < 32'(MAX_DIM));
	assign waddr = ADDR_W'(cmd.ld_row) * ADDR_W'(MAX_DIM) + ADDR_W'(cmd.ld_col);

	// Read addresses: A[i][k], B[k][j]
	assign a_raddr = ADDR_W'(cmd.i) * ADDR_W'(MAX_DIM) + ADDR_W'(cmd.k);
	assign b_raddr = ADDR_W'(cmd.k) * ADDR_W'(MAX_DIM) + ADDR_W'(cmd.j);

	mm_ram #(
		.WIDTH (VAL_W),
		.DEPTH (DEPTH)
	) u_a_ram (
		.clk   (clk),
		.we    (cmd.load_a && ld_in_range),
		.waddr (waddr),
		.wdata (cmd.ld_value),
		.re    (adv),
		.raddr (a_raddr),
		.rdata (a_rdata)
	);

	mm_ram #(
		.WIDTH (VAL_W),
		.DEPTH (DEPTH)
	) u_b_ram (
		.clk   (clk),
		.we    (cmd.load_b && ld_in_range),
		.waddr (waddr),
		.wdata (cmd.ld_value),
		.re    (adv),
		.raddr (b_raddr),
		.rdata (b_rdata)
	);

	// Tag pipeline alongside the read and the multiply
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
			tag_s2 <= '0;
		end else if (adv) begin
			tag_s1.valid     <= cmd.issue;
			tag_s1.k_first   <= cmd.k_first;
			tag_s1.k_last    <= cmd.k_last;
			tag_s1.last_elem <= cmd.last_elem;
			tag_s1.row       <= cmd.i;
			tag_s1.col       <= cmd.j;
			tag_s2           <= tag_s1;
		end
	end

	// Multiply stage
	always_ff @(posedge clk) begin
		if (adv) begin
			prod_s2 <= $signed(a_rdata) * $signed(b_rdata);
		end
	end

	// Accumulate; the first inner step starts from zero
	assign sum = (tag_s2.k_first ? '0 : acc_q)
		+ {{(SUM_W-PROD_W){prod_s2[PROD_W-1]}}, prod_s2};

	always_ff @(posedge clk) begin
		if (adv && tag_s2.valid) begin
			acc_q <= sum;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= tag_s2.valid && tag_s2.k_last;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && tag_s2.valid && tag_s2.k_last) begin
			out_row_q   <= tag_s2.row;
			out_col_q   <= tag_s2.col;
			out_value_q <= sum;
			out_last_q  <= tag_s2.last_elem;
		end
	end

	assign result.valid     = out_valid_q;
	assign result.out_row   = out_row_q;
	assign result.out_col   = out_col_q;
	assign result.out_value = out_value_q;
	assign result.last      = out_last_q;

endmodule

// ===== sv/matrix_multiply.sv =====
`timescale 1ns / 1ps
// Fixed-point matrix multiply C = A x B: top level joining controller and
// datapath. Depends on mm_pkg, mm_ifs, mm_ctrl and mm_dp.
//
// Load items (opcode 0 for A, 1 for B) write one signed Q8.8 element and are
// taken one per cycle while no compute runs; a load with row or column at or
// beyond MAX_DIM is dropped. A compute item (opcode 2) emits every element of
// C in row-major order as exact Q20.16 sums, the final one flagged by last.
// Sizes come from the rows_a, inner_dim and cols_b registers, where 0 acts as
// 1 and values above min(MAX_DIM, 8) act as that limit. A single multiply-
// accumulate unit does one inner product term per cycle while no result is
// held, so a compute item keeps the input closed until all rows_a x cols_b x
// inner_dim terms are issued; each result passes the store read, multiply
// and accumulate-result registers. A result not taken holds the whole pipeline.
// Elements of A and B must be written before a compute reads them.
module matrix_multiply #(
	parameter int MAX_DIM = mm_pkg::MAX_DIM_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	mm_item_if.sink     item,
	mm_result_if.source result,
	mm_cfg_if.sink      cfg
);
	import mm_pkg::*;

	mm_cmd_t cmd;
	mm_sts_t sts;

	mm_ctrl #(
		.MAX_DIM (MAX_DIM)
	) u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.cfg    (cfg),
		.sts    (sts),
		.cmd    (cmd)
	);

	mm_dp #(
		.MAX_DIM (MAX_DIM)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.sts    (sts),
		.result (result)
	);

endmodule

// ===== tb/matrix_multiply_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for matrix_multiply: loads A and B, issues computes
// and checks every result element against an in-bench fixed-point predictor.
// Depends on mm_pkg, mm_ifs and the matrix_multiply RTL.
module matrix_multiply_tb;
	import mm_pkg::*;

	localparam int MAX_DIM     = MAX_DIM_DEF;
	localparam int CYCLE_LIMIT = 600000;
	localparam int IDLE_SETTLE = 16;
	localparam int LONG_HOLD   = 300;

	// Opcode the block has no use for
	localparam logic [OPC_W-1:0] OP_UNUSED = 2'd3;

	// One input transaction waiting to be driven
	typedef struct {
		logic [OPC_W-1:0] op;
		logic [IDX_W-1:0] row;
		logic [IDX_W-1:0] col;
		logic [VAL_W-1:0] value;
	} mm_req_t;

	// One element of C as it should come out
	typedef struct {
		logic [IDX_W-1:0] row;
		logic [IDX_W-1:0] col;
		logic [SUM_W-1:0] value;
		logic             last;
	} c_elem_t;

	logic clk;
	logic arst_n;

	mm_item_if   item_ch ();
	mm_result_if res_ch ();
	mm_cfg_if    cfg_ch ();

	matrix_multiply #(
		.MAX_DIM(MAX_DIM)
	) i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (res_ch),
		.cfg    (cfg_ch)
	);

	// Predictor state: stores and size registers as the block holds them
	logic signed [VAL_W-1:0] a_mem [MAX_DIM*MAX_DIM];
	logic signed [VAL_W-1:0] b_mem [MAX_DIM*MAX_DIM];
	logic [CFG_W-1:0]        dim_rows  = DIM_RESET;
	logic [CFG_W-1:0]        dim_inner = DIM_RESET;
	logic [CFG_W-1:0]        dim_cols  = DIM_RESET;

	// Stimulus-side view of which entries have been written
	bit gen_wr_a [MAX_DIM*MAX_DIM];
	bit gen_wr_b [MAX_DIM*MAX_DIM];

	mm_req_t item_backlog [$];
	c_elem_t c_elems_due [$];

	int unsigned err_cnt       = 0;
	int unsigned items_taken   = 0;
	int unsigned computes_sent = 0;
	int unsigned elems_checked = 0;
	int unsigned reg_writes    = 0;
	int unsigned stim_cnt      = 0;
	int unsigned cycle_cnt     = 0;
	int unsigned tx_gap        = 0;
	int unsigned rx_hold       = 0;
	bit          tx_quiet      = 0;
	bit          rx_quiet      = 0;
	bit          long_hold_done = 0;

	// Size register as the block uses it: 0 acts as 1, big values clamp
	function automatic int eff_dim(input logic [CFG_W-1:0] d);
		int lim;
		lim = (MAX_DIM < INDEX_REACH) ? MAX_DIM : INDEX_REACH;
		if (d == 0)
			return 1;
		return (int'(d) > lim) ? lim : int'(d);
	endfunction

	// Apply one accepted transaction; computes queue every element of C
	function automatic void predict_product(input logic [OPC_W-1:0] op,
			input logic [IDX_W-1:0] r, input logic [IDX_W-1:0] c,
			input logic [VAL_W-1:0] v);
		int nr;
		int nk;
		int nc;
		logic signed [63:0] acc;
		c_elem_t el;
		case (op)
			OP_LOAD_A: begin
				if (r < MAX_DIM && c < MAX_DIM)
					a_mem[r*MAX_DIM + c] = v;
			end
			OP_LOAD_B: begin
				if (r < MAX_DIM && c < MAX_DIM)
					b_mem[r*MAX_DIM + c] = v;
			end
			OP_COMPUTE: begin
				nr = eff_dim(dim_rows);
				nk = eff_dim(dim_inner);
				nc = eff_dim(dim_cols);
				for (int i = 0; i < nr; i++) begin
					for (int j = 0; j < nc; j++) begin
						acc = 0;
						for (int k = 0; k < nk; k++)
							acc = acc + a_mem[i*MAX_DIM + k] * b_mem[k*MAX_DIM + j];
						el.row   = IDX_W'(i);
						el.col   = IDX_W'(j);
						el.value = acc[SUM_W-1:0];
						el.last  = (i == nr - 1) && (j == nc - 1);
						c_elems_due = {c_elems_due, el};
					end
				end
			end
			default: ;
		endcase
	endfunction

	// Element values lean towards the Q8.8 extremes
	function automatic logic [VAL_W-1:0] rand_value();
		case ($urandom_range(0, 15))
			0, 1: return 16'h8000;
			2, 3: return 16'h7fff;
			4:    return 16'h0000;
			default: return VAL_W'($urandom);
		endcase
	endfunction

	task automatic queue_item(input logic [OPC_W-1:0] op, input logic [IDX_W-1:0] r,
			input logic [IDX_W-1:0] c, input logic [VAL_W-1:0] v);
		mm_req_t req;
		req.op    = op;
		req.row   = r;
		req.col   = c;
		req.value = v;
		item_backlog = {item_backlog, req};
		if (op == OP_LOAD_A)
			gen_wr_a[r*MAX_DIM + c] = 1'b1;
		else if (op == OP_LOAD_B)
			gen_wr_b[r*MAX_DIM + c] = 1'b1;
		if (op != OP_UNUSED)
			stim_cnt++;
		if (op == OP_COMPUTE)
			computes_sent++;
	endtask

	// Write every operand entry the current sizes read that is still blank,
	// and rewrite some of the others with fresh content
	task automatic fill_operands();
		int nr;
		int nk;
		int nc;
		nr = eff_dim(dim_rows);
		nk = eff_dim(dim_inner);
		nc = eff_dim(dim_cols);
		for (int i = 0; i < nr; i++)
			for (int k = 0; k < nk; k++)
				if (!gen_wr_a[i*MAX_DIM + k] || $urandom_range(0, 1))
					queue_item(OP_LOAD_A, IDX_W'(i), IDX_W'(k), rand_value());
		for (int k = 0; k < nk; k++)
			for (int j = 0; j < nc; j++)
				if (!gen_wr_b[k*MAX_DIM + j] || $urandom_range(0, 1))
					queue_item(OP_LOAD_B, IDX_W'(k), IDX_W'(j), rand_value());
	endtask

	// Block is idle: nothing to drive, nothing due, pipeline given time to drain
	task automatic wait_idle();
		while (item_backlog.size() != 0 || item_ch.valid || c_elems_due.size() != 0)
			@(posedge clk);
		repeat (IDLE_SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		@(posedge clk);
		cfg_ch.index <= idx;
		cfg_ch.data  <= val;
		cfg_ch.valid <= 1'b1;
		do
			@(posedge clk);
		while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		case (idx)
			REG_ROWS_A:    dim_rows  = val;
			REG_INNER_DIM: dim_inner = val;
			REG_COLS_B:    dim_cols  = val;
			default: ;
		endcase
		reg_writes++;
	endtask

	task automatic set_dims(input logic [CFG_W-1:0] r, input logic [CFG_W-1:0] k,
			input logic [CFG_W-1:0] c);
		wait_idle();
		write_reg(REG_ROWS_A, r);
		write_reg(REG_INNER_DIM, k);
		write_reg(REG_COLS_B, c);
	endtask

	// Clock and the single reset pulse
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		arst_n       = 1'b0;
		item_ch.valid  = 1'b0;
		item_ch.opcode = OP_LOAD_A;
		item_ch.row    = '0;
		item_ch.col    = '0;
		item_ch.value  = '0;
		res_ch.ready   = 1'b0;
		cfg_ch.valid   = 1'b0;
		cfg_ch.index   = REG_ROWS_A;
		cfg_ch.data    = DIM_RESET;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
	end

	// Input driver: one transaction per handshake, random gaps between them
	always @(posedge clk) begin : drive_items
		mm_req_t nxt;
		if (arst_n) begin
			if (item_ch.valid && item_ch.ready) begin
				predict_product(item_ch.opcode, item_ch.row, item_ch.col, item_ch.value);
				items_taken++;
			end
			if (!item_ch.valid || item_ch.ready) begin
				if (tx_gap != 0) begin
					item_ch.valid <= 1'b0;
					tx_gap--;
				end else if (item_backlog.size() != 0) begin
					nxt = item_backlog.pop_front();
					item_ch.opcode <= nxt.op;
					item_ch.row    <= nxt.row;
					item_ch.col    <= nxt.col;
					item_ch.value  <= nxt.value;
					item_ch.valid  <= 1'b1;
					if ($urandom_range(0, 23) == 0)
						tx_quiet = !tx_quiet;
					tx_gap = tx_quiet ? 0 : $urandom_range(0, 7);
				end else begin
					item_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Result monitor: compare against the oldest due element, then stall
	always @(posedge clk) begin : check_results
		c_elem_t due;
		int unsigned hold;
		if (arst_n) begin
			hold = rx_hold;
			if (res_ch.valid && res_ch.ready) begin
				if (c_elems_due.size() == 0) begin
					$error("unexpected result element at row %0d col %0d",
						res_ch.out_row, res_ch.out_col);
					err_cnt++;
				end else begin
					due = c_elems_due.pop_front();
					if (res_ch.out_row !== due.row) begin
						$error("out_row: expected %0d, got %0d", due.row, res_ch.out_row);
						err_cnt++;
					end
					if (res_ch.out_col !== due.col) begin
						$error("out_col: expected %0d, got %0d", due.col, res_ch.out_col);
						err_cnt++;
					end
					if (res_ch.out_value !== due.value) begin
						$error("out_value: expected %0d, got %0d",
							$signed(due.value), $signed(res_ch.out_value));
						err_cnt++;
					end
					if (res_ch.last !== due.last) begin
						$error("last: expected %0d, got %0d", due.last, res_ch.last);
						err_cnt++;
					end
				end
				elems_checked++;
				if ($urandom_range(0, 23) == 0)
					rx_quiet = !rx_quiet;
				hold = rx_quiet ? 0 : $urandom_range(0, 7);
				// one long hold mid-compute with more input still queued
				if (!long_hold_done && c_elems_due.size() > 4 && item_backlog.size() != 0) begin
					hold = LONG_HOLD;
					long_hold_done = 1'b1;
				end
			end
			if (hold != 0) begin
				res_ch.ready <= 1'b0;
				rx_hold = hold - 1;
			end else begin
				res_ch.ready <= 1'b1;
				rx_hold = 0;
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// Stimulus
	initial begin : stimulus
		logic [CFG_W-1:0] dr;
		logic [CFG_W-1:0] dk;
		logic [CFG_W-1:0] dc;
		int nr;
		int nk;
		int nc;
		wait (arst_n);
		@(posedge clk);

		// Directed: 1x1 products at the Q8.8 extremes
		set_dims(4'd1, 4'd1, 4'd1);
		queue_item(OP_LOAD_A, 3'd0, 3'd0, 16'h8000);
		queue_item(OP_LOAD_B, 3'd0, 3'd0, 16'h8000);
		queue_item(OP_COMPUTE, 3'd0, 3'd0, 16'h0000);
		queue_item(OP_LOAD_A, 3'd0, 3'd0, 16'h7fff);
		queue_item(OP_COMPUTE, 3'd7, 3'd7, 16'hffff);
		queue_item(OP_LOAD_B, 3'd0, 3'd0, 16'h7fff);
		queue_item(OP_COMPUTE, 3'd0, 3'd0, 16'h0000);
		// unused opcode must be dropped
		queue_item(OP_UNUSED, 3'd7, 3'd7, 16'hffff);
		queue_item(OP_LOAD_A, 3'd7, 3'd7, 16'h7fff);
		queue_item(OP_LOAD_B, 3'd7, 3'd7, 16'h8000);
		queue_item(OP_LOAD_A, 3'd0, 3'd0, 16'h0000);
		queue_item(OP_COMPUTE, 3'd0, 3'd0, 16'h0000);

		// Directed: zero sizes act as one
		set_dims(4'd0, 4'd0, 4'd0);
		queue_item(OP_LOAD_A, 3'd0, 3'd0, 16'hffff);
		queue_item(OP_COMPUTE, 3'd0, 3'd0, 16'h0000);

		// Directed: 2x2x2 with mixed signs
		set_dims(4'd2, 4'd2, 4'd2);
		queue_item(OP_LOAD_A, 3'd0, 3'd0, 16'h8000);
		queue_item(OP_LOAD_A, 3'd0, 3'd1, 16'h7fff);
		queue_item(OP_LOAD_A, 3'd1, 3'd0, 16'h0100);
		queue_item(OP_LOAD_A, 3'd1, 3'd1, 16'hff00);
		queue_item(OP_LOAD_B, 3'd0, 3'd0, 16'h8000);
		queue_item(OP_LOAD_B, 3'd0, 3'd1, 16'h0001);
		queue_item(OP_LOAD_B, 3'd1, 3'd0, 16'h7fff);
		queue_item(OP_LOAD_B, 3'd1, 3'd1, 16'hffff);
		queue_item(OP_COMPUTE, 3'd0, 3'd0, 16'h0000);

		// Random phases: mostly small sizes, now and then one large or odd register
		while (stim_cnt < 40) begin
			dr = CFG_W'($urandom_range(0, 4));
			dk = CFG_W'($urandom_range(0, 4));
			dc = CFG_W'($urandom_range(0, 4));
			case ($urandom_range(0, 5))
				0: dr = CFG_W'($urandom_range(0, 15));
				1: dk = CFG_W'($urandom_range(0, 15));
				2: dc = CFG_W'($urandom_range(0, 15));
				default: ;
			endcase
			set_dims(dr, dk, dc);
			nr = eff_dim(dim_rows);
			nk = eff_dim(dim_inner);
			nc = eff_dim(dim_cols);
			// noise: loads anywhere in the stores and the odd unused opcode
			repeat ($urandom_range(0, 3))
				queue_item($urandom_range(0, 1) ? OP_LOAD_B : OP_LOAD_A,
					IDX_W'($urandom), IDX_W'($urandom), rand_value());
			if ($urandom_range(0, 3) == 0)
				queue_item(OP_UNUSED, IDX_W'($urandom), IDX_W'($urandom), VAL_W'($urandom));
			fill_operands();
			queue_item(OP_COMPUTE, IDX_W'($urandom), IDX_W'($urandom), VAL_W'($urandom));
			// touch a few operands and go again
			repeat ($urandom_range(1, 3)) begin
				if ($urandom_range(0, 1))
					queue_item(OP_LOAD_A, IDX_W'($urandom_range(0, nr - 1)),
						IDX_W'($urandom_range(0, nk - 1)), rand_value());
				else
					queue_item(OP_LOAD_B, IDX_W'($urandom_range(0, nk - 1)),
						IDX_W'($urandom_range(0, nc - 1)), rand_value());
			end
			queue_item(OP_COMPUTE, IDX_W'($urandom), IDX_W'($urandom), VAL_W'($urandom));
		end

		// Full size, registers above the limit; widest positive and negative sums
		set_dims(4'd8, 4'd15, 4'd9);
		for (int i = 0; i < 8; i++)
			for (int k = 0; k < 8; k++)
				queue_item(OP_LOAD_A, IDX_W'(i), IDX_W'(k), 16'h8000);
		for (int k = 0; k < 8; k++)
			for (int j = 0; j < 8; j++)
				queue_item(OP_LOAD_B, IDX_W'(k), IDX_W'(j),
					(j == 0) ? 16'h8000 : (j == 1) ? 16'h7fff : rand_value());
		queue_item(OP_COMPUTE, 3'd0, 3'd0, 16'h0000);
		repeat (4)
			queue_item(OP_LOAD_A, IDX_W'($urandom), IDX_W'($urandom), rand_value());
		queue_item(OP_COMPUTE, 3'd0, 3'd0, 16'h0000);

		// Drain and report
		wait_idle();
		$display("Run covered %0d transactions (%0d computes), %0d result elements,",
			items_taken, computes_sent, elems_checked);
		$display("%0d register writes; long result stall exercised: %0d",
			reg_writes, long_hold_done);
		if (err_cnt == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
